// ----- rtl/tkn_pkg.sv -----
// tkn_pkg: shared types and constants of the source text tokenizer
// holds scan modes, token codes, character codes, the result record and register map
// no dependencies
package tkn_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_COMMENT  = 3'd1,
    MODE_NUMBER   = 3'd2,
    MODE_NAME     = 3'd3,
    MODE_LBRACKET = 3'd4,
    MODE_MINUS    = 3'd5,
    MODE_COLON    = 3'd6
  } scan_mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NUMERAL_MIN = 2'd0,
    REG_NUMERAL_MAX = 2'd1,
    REG_NAME_LIMIT  = 2'd2
  } cfg_reg_e;

  localparam int unsigned TOKEN_W = 5;
  localparam int unsigned CFG_ADDR_W = 4;

  // token codes
  localparam logic [4:0] TOK_NAME_CHAR   = 5'd0;
  localparam logic [4:0] TOK_NAME_END    = 5'd1;
  localparam logic [4:0] TOK_BAD_NAME    = 5'd2;
  localparam logic [4:0] TOK_NUMERAL     = 5'd3;
  localparam logic [4:0] TOK_BAD_NUMERAL = 5'd4;
  localparam logic [4:0] TOK_NEWLINE     = 5'd5;
  localparam logic [4:0] TOK_COMMENT     = 5'd6;
  localparam logic [4:0] TOK_BAD_SYMBOL  = 5'd7;
  localparam logic [4:0] TOK_SEMI        = 5'd8;
  localparam logic [4:0] TOK_DOT         = 5'd9;
  localparam logic [4:0] TOK_COMMA       = 5'd10;
  localparam logic [4:0] TOK_LBRACKET    = 5'd11;
  localparam logic [4:0] TOK_BRACKETS    = 5'd12;
  localparam logic [4:0] TOK_RBRACKET    = 5'd13;
  localparam logic [4:0] TOK_AMP         = 5'd14;
  localparam logic [4:0] TOK_BAR         = 5'd15;
  localparam logic [4:0] TOK_TILDE       = 5'd16;
  localparam logic [4:0] TOK_LESS        = 5'd17;
  localparam logic [4:0] TOK_EQUAL       = 5'd18;
  localparam logic [4:0] TOK_GREATER     = 5'd19;
  localparam logic [4:0] TOK_BACKSLASH   = 5'd20;
  localparam logic [4:0] TOK_PLUS        = 5'd21;
  localparam logic [4:0] TOK_MINUS       = 5'd22;
  localparam logic [4:0] TOK_ARROW       = 5'd23;
  localparam logic [4:0] TOK_STAR        = 5'd24;
  localparam logic [4:0] TOK_SLASH       = 5'd25;
  localparam logic [4:0] TOK_LPAREN      = 5'd26;
  localparam logic [4:0] TOK_RPAREN      = 5'd27;
  localparam logic [4:0] TOK_COLON       = 5'd28;
  localparam logic [4:0] TOK_ASSIGN      = 5'd29;

  // character codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // register reset values
  localparam logic [31:0] NUMERAL_MIN_RST = 32'd0;
  localparam logic [31:0] NUMERAL_MAX_RST = 32'd32767;
  localparam logic [7:0]  NAME_LIMIT_RST  = 8'd80;

  typedef struct packed {
    logic [31:0] numeral_min;
    logic [31:0] numeral_max;
    logic [7:0]  name_limit;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  token;
    logic [31:0] value;
    logic [7:0]  char_out;
    logic [7:0]  name_length;
    logic        last;
  } res_t;

  // outcome of scanning one character from the idle mode
  typedef struct packed {
    logic       has_res;
    res_t       res;
    scan_mode_e mode;
    logic       digit_load;
    logic       name_start;
  } idle_t;

  // results of one step
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

// ----- rtl/tkn_cfg.sv -----
// tkn_cfg: apb register file of the tokenizer (numeral bounds and name limit)
// depends on tkn_pkg
module tkn_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkn_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tkn_pkg::cfg_t                    cfg_o
);

  tkn_pkg::cfg_t    cfg_q, cfg_d;
  tkn_pkg::cfg_reg_e sel;
  logic             wr_en;

  assign pready = 1'b1;
  assign sel    = tkn_pkg::cfg_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = 32'd0;
    case (sel)
      tkn_pkg::REG_NUMERAL_MIN: begin
        prdata = cfg_q.numeral_min;
        if (wr_en) cfg_d.numeral_min = pwdata;
      end
      tkn_pkg::REG_NUMERAL_MAX: begin
        prdata = cfg_q.numeral_max;
        if (wr_en) cfg_d.numeral_max = pwdata;
      end
      tkn_pkg::REG_NAME_LIMIT: begin
        prdata = {24'd0, cfg_q.name_limit};
        if (wr_en) cfg_d.name_limit = pwdata[7:0];
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numeral_min <= tkn_pkg::NUMERAL_MIN_RST;
      cfg_q.numeral_max <= tkn_pkg::NUMERAL_MAX_RST;
      cfg_q.name_limit  <= tkn_pkg::NAME_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tkn_scan.sv -----
// tkn_scan: scanner state and the one-character step decode
// depends on tkn_pkg
module tkn_scan #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          kind_i,
  input  logic [7:0]    ch_i,
  input  tkn_pkg::cfg_t cfg_i,
  output tkn_pkg::step_t step_o
);

  localparam int unsigned CMP_W  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int unsigned WIDE_W = VALUE_BITS + 4;

  tkn_pkg::scan_mode_e    mode_q, mode_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [7:0]             cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;

  logic [WIDE_W-1:0]      acc_wide;
  logic [CMP_W-1:0]       acc_ext;
  logic                   num_ok;
  logic                   name_bad;
  logic                   is_digit;
  logic                   is_word;
  tkn_pkg::res_t          num_res;
  tkn_pkg::res_t          name_res;
  tkn_pkg::res_t          pre;
  logic                   pre_v;
  logic                   run_idle;
  tkn_pkg::idle_t         idl;

  function automatic tkn_pkg::res_t make_res(input logic [4:0] tok);
    tkn_pkg::res_t r;
    r       = '0;
    r.token = tok;
    return r;
  endfunction

  function automatic tkn_pkg::idle_t idle_scan(input logic [7:0] c);
    tkn_pkg::idle_t r;
    logic [4:0]     sym;
    r      = '0;
    r.mode = tkn_pkg::MODE_IDLE;
    case (c)
      8'h3B:   sym = tkn_pkg::TOK_SEMI;
      8'h2E:   sym = tkn_pkg::TOK_DOT;
      8'h2C:   sym = tkn_pkg::TOK_COMMA;
      8'h5D:   sym = tkn_pkg::TOK_RBRACKET;
      8'h26:   sym = tkn_pkg::TOK_AMP;
      8'h7C:   sym = tkn_pkg::TOK_BAR;
      8'h7E:   sym = tkn_pkg::TOK_TILDE;
      8'h3C:   sym = tkn_pkg::TOK_LESS;
      8'h3D:   sym = tkn_pkg::TOK_EQUAL;
      8'h3E:   sym = tkn_pkg::TOK_GREATER;
      8'h5C:   sym = tkn_pkg::TOK_BACKSLASH;
      8'h2B:   sym = tkn_pkg::TOK_PLUS;
      8'h2A:   sym = tkn_pkg::TOK_STAR;
      8'h2F:   sym = tkn_pkg::TOK_SLASH;
      8'h28:   sym = tkn_pkg::TOK_LPAREN;
      8'h29:   sym = tkn_pkg::TOK_RPAREN;
      default: sym = tkn_pkg::TOK_BAD_SYMBOL;
    endcase
    if (c == tkn_pkg::CH_SPACE || c == tkn_pkg::CH_TAB) begin
      r.has_res = 1'b0;
    end else if (c == tkn_pkg::CH_NEWLINE) begin
      r.has_res = 1'b1;
      r.res     = make_res(tkn_pkg::TOK_NEWLINE);
    end else if (c == tkn_pkg::CH_DOLLAR) begin
      r.mode = tkn_pkg::MODE_COMMENT;
    end else if (c inside {[8'h30:8'h39]}) begin
      r.mode       = tkn_pkg::MODE_NUMBER;
      r.digit_load = 1'b1;
    end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      r.mode         = tkn_pkg::MODE_NAME;
      r.name_start   = 1'b1;
      r.has_res      = 1'b1;
      r.res          = make_res(tkn_pkg::TOK_NAME_CHAR);
      r.res.char_out = c;
    end else if (c == tkn_pkg::CH_LBRACKET) begin
      r.mode = tkn_pkg::MODE_LBRACKET;
    end else if (c == tkn_pkg::CH_MINUS) begin
      r.mode = tkn_pkg::MODE_MINUS;
    end else if (c == tkn_pkg::CH_COLON) begin
      r.mode = tkn_pkg::MODE_COLON;
    end else begin
      r.has_res = 1'b1;
      r.res     = make_res(sym);
      if (sym == tkn_pkg::TOK_BAD_SYMBOL) r.res.char_out = c;
    end
    return r;
  endfunction

  assign is_digit = (ch_i inside {[8'h30:8'h39]});
  assign is_word  = is_digit || (ch_i inside {[8'h41:8'h5A], [8'h61:8'h7A]}) ||
                    (ch_i == tkn_pkg::CH_UNDERSCORE);

  // acc*10 + digit, exact, so overflow shows in the top bits
  assign acc_wide = WIDE_W'({acc_q, 3'b000}) + WIDE_W'({acc_q, 1'b0}) + WIDE_W'(ch_i[3:0]);

  // pending numeral and name results
  assign acc_ext  = CMP_W'(acc_q);
  assign num_ok   = (acc_ext >= CMP_W'(cfg_i.numeral_min)) &&
                    (acc_ext <= CMP_W'(cfg_i.numeral_max));
  assign name_bad = ovf_q || (cnt_q > cfg_i.name_limit);

  always_comb begin
    num_res       = make_res(num_ok ? tkn_pkg::TOK_NUMERAL : tkn_pkg::TOK_BAD_NUMERAL);
    num_res.value = (acc_ext > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc_ext[31:0];
    name_res      = make_res(name_bad ? tkn_pkg::TOK_BAD_NAME : tkn_pkg::TOK_NAME_END);
    name_res.name_length = cnt_q;
  end

  assign idl = idle_scan(ch_i);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pre      = '0;
    pre_v    = 1'b0;
    run_idle = 1'b0;
    if (kind_i) begin
      // end of source: flush a pending numeral, name or symbol; an open comment yields nothing
      case (mode_q)
        tkn_pkg::MODE_NUMBER: begin
          pre_v = 1'b1;
          pre   = num_res;
        end
        tkn_pkg::MODE_NAME: begin
          pre_v = 1'b1;
          pre   = name_res;
        end
        tkn_pkg::MODE_LBRACKET: begin
          pre_v = 1'b1;
          pre   = make_res(tkn_pkg::TOK_LBRACKET);
        end
        tkn_pkg::MODE_MINUS: begin
          pre_v = 1'b1;
          pre   = make_res(tkn_pkg::TOK_MINUS);
        end
        tkn_pkg::MODE_COLON: begin
          pre_v = 1'b1;
          pre   = make_res(tkn_pkg::TOK_COLON);
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
      mode_d = tkn_pkg::MODE_IDLE;
      acc_d  = '0;
      cnt_d  = 8'd0;
      ovf_d  = 1'b0;
    end else begin
      case (mode_q)
        tkn_pkg::MODE_COMMENT: begin
          if (ch_i == tkn_pkg::CH_NEWLINE) begin
            pre_v  = 1'b1;
            pre    = make_res(tkn_pkg::TOK_COMMENT);
            mode_d = tkn_pkg::MODE_IDLE;
          end
        end
        tkn_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            if (acc_wide[WIDE_W-1:VALUE_BITS] != 4'd0) acc_d = '1;
            else acc_d = acc_wide[VALUE_BITS-1:0];
          end else begin
            pre_v    = 1'b1;
            pre      = num_res;
            run_idle = 1'b1;
          end
        end
        tkn_pkg::MODE_NAME: begin
          if (is_word) begin
            if (cnt_q == 8'hFF) ovf_d = 1'b1;
            else cnt_d = cnt_q + 8'd1;
            pre_v        = 1'b1;
            pre          = make_res(tkn_pkg::TOK_NAME_CHAR);
            pre.char_out = ch_i;
          end else begin
            pre_v    = 1'b1;
            pre      = name_res;
            run_idle = 1'b1;
          end
        end
        tkn_pkg::MODE_LBRACKET: begin
          pre_v = 1'b1;
          if (ch_i == tkn_pkg::CH_RBRACKET) begin
            pre    = make_res(tkn_pkg::TOK_BRACKETS);
            mode_d = tkn_pkg::MODE_IDLE;
          end else begin
            pre      = make_res(tkn_pkg::TOK_LBRACKET);
            run_idle = 1'b1;
          end
        end
        tkn_pkg::MODE_MINUS: begin
          pre_v = 1'b1;
          if (ch_i == tkn_pkg::CH_GREATER) begin
            pre    = make_res(tkn_pkg::TOK_ARROW);
            mode_d = tkn_pkg::MODE_IDLE;
          end else begin
            pre      = make_res(tkn_pkg::TOK_MINUS);
            run_idle = 1'b1;
          end
        end
        tkn_pkg::MODE_COLON: begin
          pre_v = 1'b1;
          if (ch_i == tkn_pkg::CH_EQUAL) begin
            pre    = make_res(tkn_pkg::TOK_ASSIGN);
            mode_d = tkn_pkg::MODE_IDLE;
          end else begin
            pre      = make_res(tkn_pkg::TOK_COLON);
            run_idle = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase
      // terminator rescanned from idle in the same step
      if (run_idle) begin
        mode_d = idl.mode;
        if (idl.digit_load) acc_d = VALUE_BITS'(ch_i[3:0]);
        if (idl.name_start) begin
          cnt_d = 8'd1;
          ovf_d = 1'b0;
        end
      end
    end
  end

  // pack up to two results, last flag on the final one
  always_comb begin
    step_o = '0;
    if (pre_v) begin
      step_o.r0 = pre;
      if (run_idle && idl.has_res) begin
        step_o.count   = 2'd2;
        step_o.r1      = idl.res;
        step_o.r1.last = 1'b1;
      end else begin
        step_o.count   = 2'd1;
        step_o.r0.last = 1'b1;
      end
    end else if (run_idle && idl.has_res) begin
      step_o.count   = 2'd1;
      step_o.r0      = idl.res;
      step_o.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tkn_pkg::MODE_IDLE;
      acc_q  <= '0;
      cnt_q  <= 8'd0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ----- rtl/tkn_queue.sv -----
// tkn_queue: four-entry result queue, two writes and one read per cycle
// depends on tkn_pkg
module tkn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_cnt_i,
  input  tkn_pkg::res_t  push0_i,
  input  tkn_pkg::res_t  push1_i,
  output logic           room2_o,
  output logic           valid_o,
  input  logic           ready_i,
  output tkn_pkg::res_t  head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  tkn_pkg::res_t       mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_q, wr_d;
  logic [PTR_W-1:0]    rd_q, rd_d;
  logic [PTR_W:0]      cnt_q, cnt_d;
  logic [PTR_W-1:0]    wr_nxt;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= (PTR_W+1)'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_nxt  = wr_q + PTR_W'(1);

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_cnt_i);
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_cnt_i) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_nxt] <= push1_i;
  end

endmodule

// ----- rtl/source_text_tokenizer.sv -----
// source_text_tokenizer: streaming lexical scanner with one character of lookahead
// path: an accepted item is held in the input register, steps the scanner and writes its results into the queue
// throughput: one item per cycle while each item yields at most one result and the queue has room for two;
//   an item that yields two results puts both into the result queue, which gives them out one at a time
// reset: asynchronous active low; scanner idle, result queue empty, registers at defaults
// depends on tkn_pkg, tkn_cfg, tkn_scan, tkn_queue
module source_text_tokenizer #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tkn_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // character items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [7:0]                     ch_i,
  // token items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [4:0]                     token_o,
  output logic [31:0]                    value_o,
  output logic [7:0]                     char_out_o,
  output logic [7:0]                     name_length_o,
  output logic                           last_o
);

  tkn_pkg::cfg_t  cfg;
  tkn_pkg::step_t step_res;
  tkn_pkg::res_t  head;

  // input register stage
  logic           in_vld_q, in_vld_d;
  logic           kind_q;
  logic [7:0]     ch_q;
  logic           in_acc;
  logic           step;
  logic           room2;
  logic [1:0]     push_cnt;

  tkn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held item steps once the queue can take its worst case of two results
  assign step       = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || step;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vld_d   = in_acc || (in_vld_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      ch_q   <= ch_i;
    end
  end

  tkn_scan #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (kind_q),
    .ch_i   (ch_q),
    .cfg_i  (cfg),
    .step_o (step_res)
  );

  // results enter the queue only on a real step
  assign push_cnt = step ? step_res.count : 2'd0;

  tkn_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (step_res.r0),
    .push1_i    (step_res.r1),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .head_o     (head)
  );

  // result fields straight from the queue head register
  assign token_o       = head.token;
  assign value_o       = head.value;
  assign char_out_o    = head.char_out;
  assign name_length_o = head.name_length;
  assign last_o        = head.last;

endmodule

// ----- rtl/tkn_checker.sv -----
// tkn_checker: port level checks of the tokenizer result channel
// depends on tkn_pkg; bound to source_text_tokenizer
module tkn_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [4:0]  token_o,
  input  logic [31:0] value_o,
  input  logic [7:0]  char_out_o,
  input  logic [7:0]  name_length_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_o) && $stable(value_o))
    else $error("stalled result changed");

  // only numerals carry a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_o != tkn_pkg::TOK_NUMERAL && token_o != tkn_pkg::TOK_BAD_NUMERAL
    |-> value_o == 32'd0)
    else $error("value on a non-numeral token");

  // only name ends carry a length, and a finished name is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_o != tkn_pkg::TOK_NAME_END && token_o != tkn_pkg::TOK_BAD_NAME
    |-> name_length_o == 8'd0)
    else $error("length on a non-name token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_o == tkn_pkg::TOK_NAME_END || token_o == tkn_pkg::TOK_BAD_NAME)
    |-> name_length_o != 8'd0)
    else $error("empty name closed");

  // character only on name chars and bad symbols
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_o != tkn_pkg::TOK_NAME_CHAR && token_o != tkn_pkg::TOK_BAD_SYMBOL
    |-> char_out_o == 8'd0)
    else $error("character on a token that has none");

endmodule

bind source_text_tokenizer tkn_checker u_tkn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .token_o       (token_o),
  .value_o       (value_o),
  .char_out_o    (char_out_o),
  .name_length_o (name_length_o)
);
